// ----- rtl/rotenc_pkg.sv -----
package rotenc_pkg;

    localparam int VALUE_WIDTH_DEF = 16;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEP_SIZE           = 3'd0,
        REG_MIN_VALUE           = 3'd1,
        REG_MAX_VALUE           = 3'd2,
        REG_ACCEL_ENABLE        = 3'd3,
        REG_DOUBLE_CLICK_ENABLE = 3'd4,
        REG_DIRECTION_NORMAL    = 3'd5,
        REG_HOLD_TICKS          = 3'd6,
        REG_CLICK_WINDOW        = 3'd7
    } t_reg_index;

    // Register values after reset.
    localparam logic [7:0]         STEP_SIZE_RST    = 8'd1;
    localparam logic signed [15:0] MIN_VALUE_RST    = 16'sd0;
    localparam logic signed [15:0] MAX_VALUE_RST    = 16'sd127;
    localparam logic [9:0]         HOLD_TICKS_RST   = 10'd500;
    localparam logic [9:0]         CLICK_WINDOW_RST = 10'd375;

    // Button timing.
    localparam logic [9:0] DEBOUNCE_TICKS   = 10'd4;
    localparam logic [9:0] SINGLE_CLICK_WIN = 10'd5;
    localparam logic [9:0] PRESS_SAT        = 10'd1023;

    // Acceleration: the range is divided by ACCEL_DIV through a reciprocal.
    localparam int         ACCEL_DIV   = 25;
    localparam int         ACCEL_SHIFT = 21;
    localparam int         ACCEL_RECIP = ((1 << ACCEL_SHIFT) + ACCEL_DIV - 1) / ACCEL_DIV;
    localparam int         ACCEL_W     = 12;
    localparam logic [4:0] ACCEL_SLOW  = 5'd20;
    localparam logic [4:0] ACCEL_MID   = 5'd15;
    localparam logic [4:0] ACCEL_FAST  = 5'd10;
    localparam logic [4:0] MOVE_SAT    = 5'd21;

    // Codes reported in button_status.
    localparam logic [2:0] STATUS_OPEN     = 3'd0;
    localparam logic [2:0] STATUS_CLICKED  = 3'd1;
    localparam logic [2:0] STATUS_DOUBLE   = 3'd2;
    localparam logic [2:0] STATUS_HELD     = 3'd3;
    localparam logic [2:0] STATUS_RELEASED = 3'd4;

    typedef enum logic [4:0] {
        BTN_OPEN     = 5'b00001,
        BTN_CLICKED  = 5'b00010,
        BTN_DOUBLE   = 5'b00100,
        BTN_HELD     = 5'b01000,
        BTN_RELEASED = 5'b10000
    } t_btn_state;

    typedef struct packed {
        logic                  func;
        logic                  pin_a;
        logic                  pin_b;
        logic                  button_level;
    } t_item;

    typedef struct packed {
        logic [7:0]            step_size;
        logic signed [15:0]    min_value;
        logic signed [15:0]    max_value;
        logic                  accel_enable;
        logic                  double_click_enable;
        logic                  direction_normal;
        logic [9:0]            hold_ticks;
        logic [9:0]            click_window;
        logic [ACCEL_W-1:0]    accel_mag;
        logic                  accel_neg;
    } t_cfg;

    typedef struct packed {
        logic                  click_event;
        logic                  double_click_event;
        logic                  hold_event;
        logic [2:0]            button_status;
    } t_btn_res;

    typedef struct packed {
        logic signed [15:0]    current_value;
        logic                  value_changed;
    } t_mot_res;

    function automatic logic [2:0] status_code(input t_btn_state state);
        logic [2:0] code;
        case (state)
            BTN_OPEN:     code = STATUS_OPEN;
            BTN_CLICKED:  code = STATUS_CLICKED;
            BTN_DOUBLE:   code = STATUS_DOUBLE;
            BTN_HELD:     code = STATUS_HELD;
            BTN_RELEASED: code = STATUS_RELEASED;
            default:      code = STATUS_OPEN;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/rotenc_cfg.sv -----
module rotenc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rotenc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rotenc_pkg::t_cfg                    o_cfg
);
    import rotenc_pkg::*;

    logic                r_live;
    logic [7:0]          r_step_size;
    logic signed [15:0]  r_min_value;
    logic signed [15:0]  r_max_value;
    logic                r_accel_enable;
    logic                r_double_click_enable;
    logic                r_direction_normal;
    logic [9:0]          r_hold_ticks;
    logic [9:0]          r_click_window;
    logic [ACCEL_W-1:0]  r_accel_mag;
    logic                r_accel_neg;

    logic [ACCEL_W-1:0]  n_accel_mag;
    logic                n_accel_neg;
    logic signed [16:0]  w_range;
    logic [15:0]         w_range_mag;
    logic [32:0]         w_recip_prod;

    assign o_cfg_ready = r_live;

    // The acceleration base is registered from the clamp range and follows it in the cycle after a
    // write, so an item stepped in that cycle can still use the old base.
    assign w_range      = 17'(r_max_value) - 17'(r_min_value);
    assign w_range_mag  = w_range[16] ? 16'(-w_range) : w_range[15:0];
    assign w_recip_prod = 33'(w_range_mag) * 33'(ACCEL_RECIP);
    assign n_accel_mag  = w_recip_prod[ACCEL_SHIFT +: ACCEL_W];
    assign n_accel_neg  = w_range[16];

    always_ff @(posedge i_clk) begin
        r_accel_mag <= n_accel_mag;
        r_accel_neg <= n_accel_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live                <= 1'b0;
            r_step_size           <= STEP_SIZE_RST;
            r_min_value           <= MIN_VALUE_RST;
            r_max_value           <= MAX_VALUE_RST;
            r_accel_enable        <= 1'b0;
            r_double_click_enable <= 1'b1;
            r_direction_normal    <= 1'b1;
            r_hold_ticks          <= HOLD_TICKS_RST;
            r_click_window        <= CLICK_WINDOW_RST;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_valid && r_live) begin
                case (t_reg_index'(i_cfg_index))
                    REG_STEP_SIZE:           r_step_size           <= i_cfg_data[7:0];
                    REG_MIN_VALUE:           r_min_value           <= i_cfg_data;
                    REG_MAX_VALUE:           r_max_value           <= i_cfg_data;
                    REG_ACCEL_ENABLE:        r_accel_enable        <= i_cfg_data[0];
                    REG_DOUBLE_CLICK_ENABLE: r_double_click_enable <= i_cfg_data[0];
                    REG_DIRECTION_NORMAL:    r_direction_normal    <= i_cfg_data[0];
                    REG_HOLD_TICKS:          r_hold_ticks          <= i_cfg_data[9:0];
                    REG_CLICK_WINDOW:        r_click_window        <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.step_size           = r_step_size;
        o_cfg.min_value           = r_min_value;
        o_cfg.max_value           = r_max_value;
        o_cfg.accel_enable        = r_accel_enable;
        o_cfg.double_click_enable = r_double_click_enable;
        o_cfg.direction_normal    = r_direction_normal;
        o_cfg.hold_ticks          = r_hold_ticks;
        o_cfg.click_window        = r_click_window;
        o_cfg.accel_mag           = r_accel_mag;
        o_cfg.accel_neg           = r_accel_neg;
    end

endmodule

// ----- rtl/rotenc_button.sv -----
module rotenc_button (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_tick,
    input  logic                 i_button_level,
    input  rotenc_pkg::t_cfg     i_cfg,
    output rotenc_pkg::t_btn_res o_res
);
    import rotenc_pkg::*;

    t_btn_state  r_state;
    logic [9:0]  r_press;
    logic [9:0]  r_window;

    t_btn_state  n_state;
    logic [9:0]  n_press;
    logic [9:0]  n_window;
    logic [9:0]  w_press_inc;
    logic        w_click;
    logic        w_dclick;
    logic        w_hold;

    assign w_press_inc = (r_press == PRESS_SAT) ? r_press : r_press + 10'd1;

    always_comb begin
        n_state  = r_state;
        n_press  = r_press;
        n_window = r_window;
        w_click  = 1'b0;
        w_dclick = 1'b0;
        w_hold   = 1'b0;
        if (i_tick) begin
            if (!i_button_level) begin
                n_press = w_press_inc;
                if (w_press_inc > i_cfg.hold_ticks) begin
                    n_state = BTN_HELD;
                    w_hold  = 1'b1;
                end
            end else begin
                // A release only counts after a press longer than the debounce time.
                if (r_press > DEBOUNCE_TICKS) begin
                    if (r_state == BTN_HELD) begin
                        n_state  = BTN_RELEASED;
                        n_window = '0;
                    end else if (r_window > SINGLE_CLICK_WIN) begin
                        if (r_window < i_cfg.click_window) begin
                            n_state  = BTN_DOUBLE;
                            n_window = '0;
                            w_dclick = 1'b1;
                        end else begin
                            w_click = 1'b1;
                        end
                    end else begin
                        n_window = i_cfg.double_click_enable ? i_cfg.click_window
                                                             : SINGLE_CLICK_WIN;
                        w_click  = 1'b1;
                    end
                end
                n_press = '0;
            end
            if (n_window != '0) begin
                n_window = n_window - 10'd1;
                if (n_window == '0) begin
                    n_state = BTN_CLICKED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BTN_OPEN;
            r_press  <= '0;
            r_window <= '0;
        end else if (i_step) begin
            r_state  <= n_state;
            r_press  <= n_press;
            r_window <= n_window;
        end
    end

    always_comb begin
        o_res.click_event        = w_click;
        o_res.double_click_event = w_dclick;
        o_res.hold_event         = w_hold;
        o_res.button_status      = status_code(n_state);
    end

endmodule

// ----- rtl/rotenc_motion.sv -----
module rotenc_motion #(
    parameter int VALUE_WIDTH = rotenc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  rotenc_pkg::t_item    i_item,
    input  rotenc_pkg::t_cfg     i_cfg,
    output rotenc_pkg::t_mot_res o_res
);
    import rotenc_pkg::*;

    localparam int PROD_W = 23;
    localparam int SUM_W  = ((VALUE_WIDTH > PROD_W) ? VALUE_WIDTH : PROD_W) + 2;
    localparam logic signed [SUM_W-1:0] V_MAX =
        {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] V_MIN =
        {{(SUM_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

    logic [1:0]                    r_prev_pins;
    logic signed [15:0]            r_count;
    logic [4:0]                    r_ticks_move;
    logic signed [VALUE_WIDTH-1:0] r_value;

    logic [1:0]                    n_prev_pins;
    logic signed [15:0]            n_count;
    logic [4:0]                    n_ticks_move;
    logic signed [VALUE_WIDTH-1:0] n_value;

    logic [3:0]                    w_trans;
    logic                          w_fwd;
    logic                          w_rev;
    logic                          w_inc;
    logic                          w_dec;
    logic signed [13:0]            w_det;
    logic                          w_moved;
    logic [ACCEL_W-1:0]            w_accel_mag;
    logic signed [ACCEL_W:0]       w_accel;
    logic signed [ACCEL_W:0]       w_term;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [SUM_W-1:0]       w_bound;
    logic                          w_hit;
    logic                          w_changed;

    // Previous pins in the low two bits, new pins above them.
    assign w_trans = {i_item.pin_b, i_item.pin_a, r_prev_pins};

    always_comb begin
        w_fwd = 1'b0;
        w_rev = 1'b0;
        case (w_trans)
            4'd2, 4'd4, 4'd11, 4'd13: w_fwd = 1'b1;
            4'd1, 4'd7, 4'd8, 4'd14:  w_rev = 1'b1;
            default: begin
            end
        endcase
    end

    assign w_inc = i_cfg.direction_normal ? w_fwd : w_rev;
    assign w_dec = i_cfg.direction_normal ? w_rev : w_fwd;

    // Whole detents are the floored quarter of the count.
    assign w_det   = r_count[15:2];
    assign w_moved = (w_det != '0);

    always_comb begin
        if (r_ticks_move > ACCEL_SLOW) begin
            w_accel_mag = '0;
        end else if (r_ticks_move > ACCEL_MID) begin
            w_accel_mag = i_cfg.accel_mag >> 2;
        end else if (r_ticks_move > ACCEL_FAST) begin
            w_accel_mag = i_cfg.accel_mag >> 1;
        end else begin
            w_accel_mag = i_cfg.accel_mag;
        end
    end

    always_comb begin
        if (!i_cfg.accel_enable) begin
            w_accel = '0;
        end else if (i_cfg.accel_neg) begin
            w_accel = -$signed({1'b0, w_accel_mag});
        end else begin
            w_accel = $signed({1'b0, w_accel_mag});
        end
    end

    assign w_term = w_det[13] ? -w_accel : w_accel;
    assign w_prod = PROD_W'($signed({1'b0, i_cfg.step_size})) * PROD_W'(w_det);
    assign w_sum  = SUM_W'(r_value) + SUM_W'(w_prod) + SUM_W'(w_term);

    // Clamp to the configured range (the maximum wins if the range is
    // inverted), then saturate to the width of the value register.
    always_comb begin
        w_bound = w_sum;
        w_hit   = 1'b0;
        if (w_bound < SUM_W'(i_cfg.min_value)) begin
            w_bound = SUM_W'(i_cfg.min_value);
            w_hit   = 1'b1;
        end
        if (w_bound > SUM_W'(i_cfg.max_value)) begin
            w_bound = SUM_W'(i_cfg.max_value);
            w_hit   = 1'b1;
        end
        if (w_bound > V_MAX) begin
            w_bound = V_MAX;
        end
        if (w_bound < V_MIN) begin
            w_bound = V_MIN;
        end
    end

    always_comb begin
        n_prev_pins  = r_prev_pins;
        n_count      = r_count;
        n_ticks_move = r_ticks_move;
        n_value      = r_value;
        w_changed    = 1'b0;
        if (!i_item.func) begin
            n_prev_pins = {i_item.pin_b, i_item.pin_a};
            if (r_ticks_move < MOVE_SAT) begin
                n_ticks_move = r_ticks_move + 5'd1;
            end
            if (w_inc && (r_count != 16'sh7fff)) begin
                n_count = r_count + 16'sd1;
            end else if (w_dec && (r_count != -16'sh8000)) begin
                n_count = r_count - 16'sd1;
            end
        end else begin
            n_count = {14'd0, r_count[1:0]};
            if (w_moved) begin
                n_ticks_move = '0;
                n_value      = VALUE_WIDTH'(w_bound);
                w_changed    = (VALUE_WIDTH'(w_bound) != r_value);
                if (w_hit) begin
                    n_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins  <= '0;
            r_count      <= '0;
            r_ticks_move <= '0;
            r_value      <= '0;
        end else if (i_step) begin
            r_prev_pins  <= n_prev_pins;
            r_count      <= n_count;
            r_ticks_move <= n_ticks_move;
            r_value      <= n_value;
        end
    end

    always_comb begin
        o_res.current_value = 16'(n_value);
        o_res.value_changed = w_changed;
    end

endmodule

// ----- rtl/rotary_encoder_with_button.sv -----
// Path: an input beat is held in the input register, then in the output register.
// Throughput: one item per cycle; the input register and the output register
// advance together, so only a stalled output beat holds the input side back.
// Reset (synchronous, active low) clears the valid flags and the button and motion state and loads
// the register defaults; both ready outputs stay low until the first cycle after reset.
module rotary_encoder_with_button #(
    parameter int VALUE_WIDTH = rotenc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata, lowest bit first: pin_a, pin_b, button_level, zero fill.
    input  logic [rotenc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: func (0 tick, 1 apply).
    input  logic                                i_s_axis_tuser,
    // Output stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata, lowest bit first: click_event, double_click_event, hold_event,
    // button_status[2:0], current_value[15:0], value_changed, zero fill.
    output logic [rotenc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rotenc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rotenc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rotenc_pkg::*;

    t_cfg                   w_cfg;
    t_btn_res               w_btn;
    t_mot_res               w_mot;

    logic                   r_in_valid;
    t_item                  r_in;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   w_advance;
    logic                   w_step;
    logic                   w_take;

    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_advance;
    assign o_s_axis_tready = o_cfg_ready && (!r_in_valid || w_advance);
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    rotenc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rotenc_button u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_tick         (!r_in.func),
        .i_button_level (r_in.button_level),
        .i_cfg          (w_cfg),
        .o_res          (w_btn)
    );

    rotenc_motion #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_motion (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_mot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.func         <= i_s_axis_tuser;
            r_in.pin_a        <= i_s_axis_tdata[0];
            r_in.pin_b        <= i_s_axis_tdata[1];
            r_in.button_level <= i_s_axis_tdata[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {1'b0, w_mot.value_changed, w_mot.current_value,
                           w_btn.button_status, w_btn.hold_event,
                           w_btn.double_click_event, w_btn.click_event};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/rotenc_checker.sv -----
module rotenc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [rotenc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import rotenc_pkg::*;

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output beat changed while stalled");

    // Presses and releases never report two button events at once.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $countones(o_m_axis_tdata[2:0]) <= 1)
        else $error("more than one button event in a beat");

    // A double click always leaves the button in the double-clicked status.
    a_dclick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[5:3] == STATUS_DOUBLE)
        else $error("double click without double-clicked status");

    // Value changes come from apply beats, button events from tick beats.
    a_change_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[22] |-> o_m_axis_tdata[2:0] == 3'b000)
        else $error("value change reported together with a button event");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind rotary_encoder_with_button rotenc_checker u_rotenc_checker (.*);

// ----- tb/rotary_encoder_with_button_test.sv -----
`timescale 1ns / 100ps

module rotary_encoder_with_button_test;
    import rotenc_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;
    localparam int   QUIET_LIMIT = 2000;

    // Quadrature levels per position, forward rotation walks 0-1-2-3.
    localparam logic [3:0] GRAY_A = 4'b0110;
    localparam logic [3:0] GRAY_B = 4'b1100;

    typedef struct packed {
        logic               click;
        logic               dclick;
        logic               hold;
        logic [2:0]         status;
        logic signed [15:0] value;
        logic               changed;
    } t_knob_res;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Register copies kept by the knob predictor.
    int step_sz  = STEP_SIZE_RST;
    int min_lim  = MIN_VALUE_RST;
    int max_lim  = MAX_VALUE_RST;
    int accel_en = 0;
    int dclick_en = 1;
    int dir_norm = 1;
    int hold_lim = HOLD_TICKS_RST;
    int win_lim  = CLICK_WINDOW_RST;

    // Knob state.
    logic [1:0] pins_last = 2'b00;
    int         count = 0;
    int         idle_ticks = 0;
    int         press_cnt = 0;
    int         window_cnt = 0;
    logic [2:0] btn_status = STATUS_OPEN;
    int         value_now = 0;
    int         shown_value = 0;

    t_item     pend_q[$];
    t_knob_res exp_q[$];

    int bad_cnt = 0;
    int quiet_cycles = 0;
    int gap_max = 0, burst_max = 1, stall_max = 0, run_max = 1;
    int gap_left = 0, burst_left = 0, stall_left = 0, run_left = 0;
    int pos = 0;
    int pushed = 0;
    logic btn_now = 1'b1;

    rotary_encoder_with_button u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic longint clip16(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic void knob_set_reg(t_reg_index idx, logic [15:0] val);
        case (idx)
            REG_STEP_SIZE:           step_sz = val[7:0];
            REG_MIN_VALUE:           min_lim = $signed(val);
            REG_MAX_VALUE:           max_lim = $signed(val);
            REG_ACCEL_ENABLE:        accel_en = val[0];
            REG_DOUBLE_CLICK_ENABLE: dclick_en = val[0];
            REG_DIRECTION_NORMAL:    dir_norm = val[0];
            REG_HOLD_TICKS:          hold_lim = val[9:0];
            REG_CLICK_WINDOW:        win_lim = val[9:0];
            default: ;
        endcase
    endfunction

    function automatic t_knob_res knob_next(t_item it);
        t_knob_res  r;
        logic [3:0] trans;
        int         dir_sign, low, det, d, boost;
        longint     v;
        r = '0;
        if (it.func == FUNC_TICK) begin
            trans = {it.pin_b, it.pin_a, pins_last};
            dir_sign = dir_norm ? 1 : -1;
            if (idle_ticks < MOVE_SAT) idle_ticks++;
            // Single steps only; a jump of two positions is ignored.
            case (trans)
                4'd1, 4'd7, 4'd8, 4'd14:  count = int'(clip16(count - dir_sign));
                4'd2, 4'd4, 4'd11, 4'd13: count = int'(clip16(count + dir_sign));
                default: ;
            endcase
            pins_last = {it.pin_b, it.pin_a};

            if (!it.button_level) begin
                if (press_cnt < PRESS_SAT) press_cnt++;
                if (press_cnt > hold_lim) begin
                    btn_status = STATUS_HELD;
                    r.hold = 1'b1;
                end
            end else begin
                if (press_cnt > DEBOUNCE_TICKS) begin
                    if (btn_status == STATUS_HELD) begin
                        btn_status = STATUS_RELEASED;
                        window_cnt = 0;
                    end else if (window_cnt > SINGLE_CLICK_WIN) begin
                        // A window left over from a larger setting only reports a click.
                        if (window_cnt < win_lim) begin
                            btn_status = STATUS_DOUBLE;
                            window_cnt = 0;
                            r.dclick = 1'b1;
                        end else begin
                            r.click = 1'b1;
                        end
                    end else begin
                        window_cnt = dclick_en ? win_lim : SINGLE_CLICK_WIN;
                        r.click = 1'b1;
                    end
                end
                press_cnt = 0;
            end
            if (window_cnt > 0) begin
                window_cnt--;
                if (window_cnt == 0) btn_status = STATUS_CLICKED;
            end
        end else begin
            low = count & 3;
            det = (count - low) / 4;
            count = low;
            boost = 0;
            if (accel_en) begin
                d = (max_lim - min_lim) / ACCEL_DIV;
                if (idle_ticks > ACCEL_SLOW) boost = 0;
                else if (idle_ticks > ACCEL_MID) boost = d / 4;
                else if (idle_ticks > ACCEL_FAST) boost = d / 2;
                else boost = d;
            end
            if (det != 0) begin
                v = longint'(value_now) + longint'(step_sz) * det;
                v += (det > 0) ? boost : -boost;
                idle_ticks = 0;
                if (v < min_lim) begin
                    v = min_lim;
                    count = 0;
                end
                if (v > max_lim) begin
                    v = max_lim;
                    count = 0;
                end
                value_now = int'(clip16(v));
                if (shown_value != value_now) begin
                    shown_value = value_now;
                    r.changed = 1'b1;
                end
            end
        end
        r.status = btn_status;
        r.value = 16'(value_now);
        return r;
    endfunction

    // Input side: bursts of beats separated by random gaps.
    always @(posedge clk) begin : drive_items
        t_item nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) exp_q.push_back(knob_next(pend_q.pop_front()));
            if (s_tvalid && !s_tready) begin
                // The beat stays on the bus until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                nxt = pend_q[0];
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, nxt.button_level, nxt.pin_b, nxt.pin_a};
                s_tuser <= nxt.func;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left = $urandom_range(0, gap_max);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: ready runs and stalls of random length.
    always @(posedge clk) begin : check_results
        t_knob_res got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.click   = m_tdata[0];
                got.dclick  = m_tdata[1];
                got.hold    = m_tdata[2];
                got.status  = m_tdata[5:3];
                got.value   = m_tdata[21:6];
                got.changed = m_tdata[22];
                if (exp_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("unexpected result beat: %h", m_tdata);
                end else begin
                    want = exp_q.pop_front();
                    if (got.click !== want.click || got.dclick !== want.dclick ||
                        got.hold !== want.hold || got.status !== want.status ||
                        got.value !== want.value || got.changed !== want.changed) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display({"mismatch: expected clk %0b dbl %0b hold %0b st %0d ",
                                      "val %0d chg %0b, got clk %0b dbl %0b hold %0b st %0d ",
                                      "val %0d chg %0b"},
                                     want.click, want.dclick, want.hold, want.status,
                                     want.value, want.changed, got.click, got.dclick,
                                     got.hold, got.status, got.value, got.changed);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                run_left--;
                if (run_left <= 0) begin
                    run_left = $urandom_range(1, run_max);
                    stall_left = $urandom_range(0, stall_max);
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pend_q.size() != 0 || exp_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        knob_set_reg(idx, val);
    endtask

    task automatic write_one(t_reg_index idx, logic [15:0] val);
        wait_drained();
        @(posedge clk);
        write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(int step, int minv, int maxv, int accel, int dcen, int dirn,
                             int hold, int win);
        wait_drained();
        @(posedge clk);
        write_reg(REG_STEP_SIZE, 16'(step));
        write_reg(REG_MIN_VALUE, 16'(minv));
        write_reg(REG_MAX_VALUE, 16'(maxv));
        write_reg(REG_ACCEL_ENABLE, 16'(accel));
        write_reg(REG_DOUBLE_CLICK_ENABLE, 16'(dcen));
        write_reg(REG_DIRECTION_NORMAL, 16'(dirn));
        write_reg(REG_HOLD_TICKS, 16'(hold));
        write_reg(REG_CLICK_WINDOW, 16'(win));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void set_pace(int gap, int burst, int stall, int run);
        gap_max = gap;
        burst_max = burst;
        stall_max = stall;
        run_max = run;
    endfunction

    function automatic void push_tick(logic a, logic b, logic btn);
        t_item it;
        it.func = FUNC_TICK;
        it.pin_a = a;
        it.pin_b = b;
        it.button_level = btn;
        pend_q.push_back(it);
        pushed++;
    endfunction

    // Pins and button ride along on an apply but are not used.
    function automatic void push_apply();
        t_item it;
        it.func = FUNC_APPLY;
        it.pin_a = $urandom_range(0, 1);
        it.pin_b = $urandom_range(0, 1);
        it.button_level = $urandom_range(0, 1);
        pend_q.push_back(it);
        pushed++;
    endfunction

    function automatic void still(int n);
        repeat (n) push_tick(GRAY_A[pos], GRAY_B[pos], btn_now);
    endfunction

    function automatic void spin(int n, int dir);
        repeat (n) begin
            pos = (pos + dir + 4) % 4;
            push_tick(GRAY_A[pos], GRAY_B[pos], btn_now);
        end
    endfunction

    function automatic void press(int n);
        btn_now = 1'b0;
        still(n);
        btn_now = 1'b1;
        still(1);
    endfunction

    function automatic void mix_items(int n);
        int goal, r, len;
        goal = pushed + n;
        while (pushed < goal) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                spin($urandom_range(1, 9), $urandom_range(0, 1) ? 1 : -1);
            end else if (r < 48) begin
                push_apply();
            end else if (r < 72) begin
                r = $urandom_range(0, 9);
                if (r < 2) len = $urandom_range(1, 4);
                else if (r < 8 || hold_lim > 60) len = $urandom_range(5, 12);
                else len = hold_lim + $urandom_range(0, 3);
                press(len);
            end else if (r < 84) begin
                // Noise: arbitrary pin jumps and button levels.
                repeat ($urandom_range(1, 3)) begin
                    pos = $urandom_range(0, 3);
                    btn_now = $urandom_range(0, 1);
                    still(1);
                end
            end else if (r < 94) begin
                spin($urandom_range(4, 12), $urandom_range(0, 1) ? 1 : -1);
                push_apply();
            end else begin
                still($urandom_range(1, 6));
            end
        end
    endfunction

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short directed run on the register defaults.
        set_pace(3, 6, 3, 8);
        spin(4, 1);
        push_apply();
        pos = (pos + 2) % 4;
        still(1);
        push_apply();
        spin(5, -1);
        push_apply();
        press(2);
        press(5);
        press(5);

        configure(255, -32768, 32767, 1, 1, 1, 20, 40);
        set_pace(4, 8, 4, 6);
        mix_items(90);

        // Minimum above maximum, reversed direction, no double-click window.
        configure(0, 100, -100, 1, 0, 0, 1, 6);
        set_pace(0, 1, 0, 1);
        mix_items(70);

        configure(3, -50, 50, 1, 1, 1, 30, 1023);
        set_pace(8, 3, 8, 3);
        mix_items(70);

        // A click leaves a long window, which then outlives a smaller setting.
        configure(1, 0, 127, 0, 1, 1, 500, 200);
        set_pace(2, 5, 2, 5);
        press(5);
        still(3);
        write_one(REG_CLICK_WINDOW, 16'd10);
        press(5);
        still(3);

        // Long spins with the button down; hold never fires at the top setting.
        configure(255, -32768, 32767, 0, 1, 1, 1023, 375);
        set_pace(0, 1, 0, 1000);
        btn_now = 1'b0;
        spin(40, 1);
        btn_now = 1'b1;
        still(1);
        push_apply();
        spin(40, -1);
        push_apply();
        press(20);
        push_apply();

        wait_drained();
        configure($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(1, 60), $urandom_range(6, 80));
        set_pace(5, 10, 5, 10);
        mix_items(100);

        wait_drained();
        repeat (10) @(posedge clk);
        if (bad_cnt == 0 && exp_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- rotary_encoder_with_button.f -----
rtl/rotenc_pkg.sv
rtl/rotenc_cfg.sv
rtl/rotenc_button.sv
rtl/rotenc_motion.sv
rtl/rotary_encoder_with_button.sv
rtl/rotenc_checker.sv
tb/rotary_encoder_with_button_test.sv
